[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the blend core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is held.
`define ARFB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion lbl failed");

// Check a property on every rising edge, reset included.
`define ARFB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion lbl failed");

`endif

[sv/arfb_pkg.sv]
// ----------------------------------------------------------------------------
// arfb_pkg
// Types and constants shared by the rectangle fill blend core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arfb_pkg;

    localparam int unsigned DIM_W   = 13;
    localparam int unsigned LEN_W   = 14;
    localparam int unsigned PIX_W   = 12;
    localparam int unsigned COLOR_W = 24;
    localparam int unsigned CH_W    = 8;
    localparam int unsigned CFG_W   = 24;
    localparam int unsigned IDX_W   = 3;
    // signed coordinate span for edge math: -4096 .. 20478
    localparam int unsigned COORD_W = 16;

    localparam logic [DIM_W-1:0] SCREEN_W_RST = 13'd1024;
    localparam logic [DIM_W-1:0] SCREEN_H_RST = 13'd768;
    localparam logic [15:0]      ROUND_BIAS   = 16'd127;

    typedef enum logic [IDX_W-1:0] {
        t_idx_screen_width  = 3'd0,
        t_idx_screen_height = 3'd1,
        t_idx_rect_left     = 3'd2,
        t_idx_rect_top      = 3'd3,
        t_idx_rect_width    = 3'd4,
        t_idx_rect_height   = 3'd5,
        t_idx_fill_color    = 3'd6,
        t_idx_fill_alpha    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        [DIM_W-1:0]   screen_width;
        logic        [DIM_W-1:0]   screen_height;
        logic signed [DIM_W-1:0]   rect_left;
        logic signed [DIM_W-1:0]   rect_top;
        logic        [LEN_W-1:0]   rect_width;
        logic        [LEN_W-1:0]   rect_height;
        logic        [COLOR_W-1:0] fill_color;
        logic        [CH_W-1:0]    fill_alpha;
    } t_cfg;

endpackage

`default_nettype wire

[sv/arfb_cfg.sv]
// ----------------------------------------------------------------------------
// arfb_cfg
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arfb_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [arfb_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [arfb_pkg::CFG_W-1:0]   i_cfg_data,
    output arfb_pkg::t_cfg                    o_cfg
);
    import arfb_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                t_idx_screen_width:  n_cfg.screen_width  = i_cfg_data[DIM_W-1:0];
                t_idx_screen_height: n_cfg.screen_height = i_cfg_data[DIM_W-1:0];
                t_idx_rect_left:     n_cfg.rect_left     = $signed(i_cfg_data[DIM_W-1:0]);
                t_idx_rect_top:      n_cfg.rect_top      = $signed(i_cfg_data[DIM_W-1:0]);
                t_idx_rect_width:    n_cfg.rect_width    = i_cfg_data[LEN_W-1:0];
                t_idx_rect_height:   n_cfg.rect_height   = i_cfg_data[LEN_W-1:0];
                t_idx_fill_color:    n_cfg.fill_color    = i_cfg_data[COLOR_W-1:0];
                t_idx_fill_alpha:    n_cfg.fill_alpha    = i_cfg_data[CH_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= SCREEN_W_RST;
            r_cfg.screen_height <= SCREEN_H_RST;
            r_cfg.rect_left     <= '0;
            r_cfg.rect_top      <= '0;
            r_cfg.rect_width    <= '0;
            r_cfg.rect_height   <= '0;
            r_cfg.fill_color    <= '0;
            r_cfg.fill_alpha    <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[sv/arfb_clip.sv]
// ----------------------------------------------------------------------------
// arfb_clip
// Registered hit test: pixel inside the rectangle, inside the screen, and
// alpha nonzero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arfb_clip #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  wire logic                         i_clk,
    input  wire arfb_pkg::t_cfg               i_cfg,
    input  wire logic [arfb_pkg::PIX_W-1:0]   i_px,
    input  wire logic [arfb_pkg::PIX_W-1:0]   i_py,
    output logic                              o_hit
);
    import arfb_pkg::*;

    logic r_hit;
    logic n_hit;
    logic w_in_x;
    logic w_in_y;

    function automatic logic axis_inside(
        input logic        [PIX_W-1:0] p,
        input logic signed [DIM_W-1:0] start,
        input logic        [LEN_W-1:0] len,
        input logic        [DIM_W-1:0] lim
    );
        logic signed [COORD_W-1:0] ps;
        logic signed [COORD_W-1:0] ss;
        logic signed [COORD_W-1:0] es;
        logic                      on_screen;
        ps = $signed({{(COORD_W-PIX_W){1'b0}}, p});
        ss = {{(COORD_W-DIM_W){start[DIM_W-1]}}, start};
        es = ss + $signed({{(COORD_W-LEN_W){1'b0}}, len});
        // screen size above MAX_DIM clamps to MAX_DIM
        on_screen = ({1'b0, p} < lim) && (32'(p) < 32'(MAX_DIM));
        return on_screen && (len != '0) && (ps >= ss) && (ps < es);
    endfunction

    always_comb begin
        w_in_x = axis_inside(i_px, i_cfg.rect_left, i_cfg.rect_width, i_cfg.screen_width);
        w_in_y = axis_inside(i_py, i_cfg.rect_top, i_cfg.rect_height, i_cfg.screen_height);
        n_hit  = w_in_x && w_in_y && (i_cfg.fill_alpha != '0);
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
    end

    assign o_hit = r_hit;

endmodule

`default_nettype wire

[sv/arfb_blend_ch.sv]
// ----------------------------------------------------------------------------
// arfb_blend_ch
// One 8-bit channel of (s*a + d*(255-a) + 127) / 255: products, sum, then a
// reciprocal divide by 255 on the registered sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arfb_blend_ch (
    input  wire logic                        i_clk,
    input  wire logic [arfb_pkg::CH_W-1:0]   i_src,
    input  wire logic [arfb_pkg::CH_W-1:0]   i_dst,
    input  wire logic [arfb_pkg::CH_W-1:0]   i_alpha,
    output logic      [arfb_pkg::CH_W-1:0]   o_mix
);
    import arfb_pkg::*;

    logic [CH_W-1:0]   w_alpha_n;
    logic [2*CH_W-1:0] r_prod_s;
    logic [2*CH_W-1:0] r_prod_d;
    logic [2*CH_W-1:0] r_sum;
    logic [2*CH_W:0]   w_sum;
    logic [2*CH_W:0]   w_quot;

    // 255 - a is the bitwise complement of a at channel width
    assign w_alpha_n = ~i_alpha;

    always_ff @(posedge i_clk) begin
        r_prod_s <= {{CH_W{1'b0}}, i_src} * {{CH_W{1'b0}}, i_alpha};
        r_prod_d <= {{CH_W{1'b0}}, i_dst} * {{CH_W{1'b0}}, w_alpha_n};
    end

    // max sum is 255*255 + 127, which fits in 16 bits
    assign w_sum = {1'b0, r_prod_s} + {1'b0, r_prod_d} + {1'b0, ROUND_BIAS};

    always_ff @(posedge i_clk) begin
        r_sum <= w_sum[2*CH_W-1:0];
    end

    // x / 255 == (x + (x >> 8) + 1) >> 8 for every x in range
    assign w_quot = {1'b0, r_sum} + {{(CH_W+1){1'b0}}, r_sum[2*CH_W-1:CH_W]}
                    + {{(2*CH_W){1'b0}}, 1'b1};
    assign o_mix  = w_quot[2*CH_W-1:CH_W];

endmodule

`default_nettype wire

[sv/alpha_rect_fill_blend_core.sv]
// ----------------------------------------------------------------------------
// alpha_rect_fill_blend_core
// Constant-alpha rectangle fill compositor for 24-bit RGB pixels.
// ----------------------------------------------------------------------------
// One pixel is accepted every clock: busy never rises, so start may be held
// high for a continuous pixel stream. Each accepted pixel comes back as a
// single-cycle o_strobe with o_new_color and o_written; the receiver must
// take it then. In order, the stages are the input register, the channel
// multipliers, the rounding sum and the divide-by-255 feeding the output
// register. Write configuration only while no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module alpha_rect_fill_blend_core #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [arfb_pkg::PIX_W-1:0]     i_pixel_x,
    input  wire logic [arfb_pkg::PIX_W-1:0]     i_pixel_y,
    input  wire logic [arfb_pkg::COLOR_W-1:0]   i_dest_color,
    output logic                                o_strobe,
    output logic      [arfb_pkg::COLOR_W-1:0]   o_new_color,
    output logic                                o_written,
    input  wire logic                           i_cfg_we,
    input  wire logic [arfb_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [arfb_pkg::CFG_W-1:0]     i_cfg_data
);
    import arfb_pkg::*;

    t_cfg               w_cfg;
    logic               w_hit_b;
    logic [COLOR_W-1:0] w_mix;

    logic               r_vld_a;
    logic [PIX_W-1:0]   r_px_a;
    logic [PIX_W-1:0]   r_py_a;
    logic [COLOR_W-1:0] r_dst_a;

    logic               r_vld_b;
    logic [COLOR_W-1:0] r_dst_b;

    logic               r_vld_c;
    logic               r_hit_c;
    logic [COLOR_W-1:0] r_dst_c;

    logic               r_strobe;
    logic [COLOR_W-1:0] r_new_color;
    logic               r_written;
    logic [COLOR_W-1:0] n_new_color;

    assign busy = 1'b0;

    arfb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // stage A: capture the transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
        end else begin
            r_vld_a <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px_a  <= i_pixel_x;
        r_py_a  <= i_pixel_y;
        r_dst_a <= i_dest_color;
    end

    arfb_clip #(
        .MAX_DIM (MAX_DIM)
    ) u_clip (
        .i_clk (i_clk),
        .i_cfg (w_cfg),
        .i_px  (r_px_a),
        .i_py  (r_py_a),
        .o_hit (w_hit_b)
    );

    for (genvar g = 0; g < COLOR_W / CH_W; g++) begin : g_ch
        arfb_blend_ch u_blend (
            .i_clk   (i_clk),
            .i_src   (w_cfg.fill_color[g*CH_W +: CH_W]),
            .i_dst   (r_dst_a[g*CH_W +: CH_W]),
            .i_alpha (w_cfg.fill_alpha),
            .o_mix   (w_mix[g*CH_W +: CH_W])
        );
    end

    // stages B and C: carry valid, hit and the original color alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_b  <= 1'b0;
            r_vld_c  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_vld_b  <= r_vld_a;
            r_vld_c  <= r_vld_b;
            r_strobe <= r_vld_c;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dst_b <= r_dst_a;
        r_dst_c <= r_dst_b;
        r_hit_c <= w_hit_b;
    end

    // pass the pixel through untouched unless it was hit
    assign n_new_color = r_hit_c ? w_mix : r_dst_c;

    always_ff @(posedge i_clk) begin
        r_new_color <= n_new_color;
        r_written   <= r_hit_c;
    end

    assign o_strobe    = r_strobe;
    assign o_new_color = r_new_color;
    assign o_written   = r_written && r_strobe;

    `ARFB_ASSERT(a_latency, i_clk, i_rst_n, r_vld_a |-> ##3 o_strobe)
    `ARFB_ASSERT(a_no_orphan, i_clk, i_rst_n, o_strobe |-> $past(r_vld_a, 3))
    `ARFB_ASSERT(a_opaque, i_clk, i_rst_n,
        (o_written && (w_cfg.fill_alpha == 8'hFF)) |-> (o_new_color == w_cfg.fill_color))
    `ARFB_ASSERT(a_clear, i_clk, i_rst_n,
        (o_strobe && (w_cfg.fill_alpha == 8'h00)) |-> !o_written)
    `ARFB_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_strobe)

endmodule

`default_nettype wire
